>>> rtl/core/assert_macros.svh
// Assertion helpers for the matrix product core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, skipped while rst is high.
`define IMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond stays low on every rising edge of clk, skipped while rst is high.
`define IMM_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/imm_pkg.sv
package imm_pkg;

   localparam int MAX_DIM_DEFAULT = 16;
   localparam int SIZE_W          = 5;
   localparam int IDX_W           = 4;
   localparam int DATA_W          = 16;
   localparam int ACC_W           = 32;
   localparam int SIZE_RESET      = 16;
   localparam int MAC_LATENCY     = 3;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

>>> rtl/core/imm_ram.sv
module imm_ram #(
   parameter int WIDTH = imm_pkg::DATA_W,
   parameter int DEPTH = imm_pkg::MAX_DIM_DEFAULT * imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/imm_ctrl.sv
module imm_ctrl #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT,
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       operation,
   input  logic [imm_pkg::IDX_W-1:0]  row,
   input  logic [imm_pkg::IDX_W-1:0]  col,
   input  logic [imm_pkg::SIZE_W-1:0] size_eff,
   output logic                       busy,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [ADDR_W-1:0]          rd_addr_a,
   output logic [ADDR_W-1:0]          rd_addr_b,
   output imm_pkg::mac_ctrl_type      mac_ctrl,
   output logic                       oor_hit
);

   localparam int K_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   imm_pkg::state_type         state_ff, state_in;
   logic [K_W-1:0]             k_ff, k_in;
   logic [K_W-1:0]             last_k_ff, last_k_in;
   logic [imm_pkg::IDX_W-1:0]  row_ff, row_in;
   logic [imm_pkg::IDX_W-1:0]  col_ff, col_in;
   logic [1:0]                 drain_ff, drain_in;
   logic                       accept;
   logic                       in_size;
   logic                       k_last;
   logic                       drain_last;

   assign accept     = start && (state_ff == imm_pkg::ST_IDLE);
   assign in_size    = ({1'b0, row} < size_eff) && ({1'b0, col} < size_eff);
   assign k_last     = (k_ff == last_k_ff);
   assign drain_last = (drain_ff == 2'(imm_pkg::MAC_LATENCY - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (accept && (operation == imm_pkg::OP_READ) && in_size) begin
               state_in = imm_pkg::ST_RUN;
            end
         end
         imm_pkg::ST_RUN: begin
            if (k_last) begin
               state_in = imm_pkg::ST_DRAIN;
            end
         end
         imm_pkg::ST_DRAIN: begin
            if (drain_last) begin
               state_in = imm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy           = (state_ff != imm_pkg::ST_IDLE);
      wr_en          = accept && (operation == imm_pkg::OP_LOAD) && in_size;
      wr_addr        = ADDR_W'(int'(row) * MAX_DIM + int'(col));
      rd_addr_a      = ADDR_W'(int'(row_ff) * MAX_DIM + int'(k_ff));
      rd_addr_b      = ADDR_W'(int'(k_ff) * MAX_DIM + int'(col_ff));
      mac_ctrl.valid = (state_ff == imm_pkg::ST_RUN);
      mac_ctrl.first = (k_ff == '0);
      mac_ctrl.last  = k_last;
      oor_hit        = accept && (operation == imm_pkg::OP_READ) && !in_size;
   end

   always_comb begin
      k_in      = k_ff;
      last_k_in = last_k_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      drain_in  = drain_ff;
      case (state_ff)
         imm_pkg::ST_IDLE: begin
            k_in      = '0;
            drain_in  = '0;
            row_in    = row;
            col_in    = col;
            last_k_in = K_W'(size_eff - imm_pkg::SIZE_W'(1));
         end
         imm_pkg::ST_RUN: begin
            k_in = k_ff + K_W'(1);
         end
         imm_pkg::ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
         end
         default: begin
            k_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
         k_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
      last_k_ff <= last_k_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
   end

endmodule

>>> rtl/core/imm_mac.sv
module imm_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  imm_pkg::mac_ctrl_type             mac_ctrl,
   input  logic signed [imm_pkg::DATA_W-1:0] a_data,
   input  logic signed [imm_pkg::DATA_W-1:0] b_data,
   output logic                              done,
   output logic        [imm_pkg::ACC_W-1:0]  sum
);

   imm_pkg::mac_ctrl_type              ctrl_d1_ff, ctrl_d2_ff;
   logic signed [imm_pkg::ACC_W-1:0]   product_ff, product_in;
   logic        [imm_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                               done_ff, done_in;

   always_comb begin
      product_in = imm_pkg::ACC_W'(a_data * b_data);
      acc_in     = acc_ff;
      if (ctrl_d2_ff.valid) begin
         acc_in = ctrl_d2_ff.first ? product_ff : acc_ff + product_ff;
      end
      done_in = ctrl_d2_ff.valid && ctrl_d2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_d1_ff <= '0;
         ctrl_d2_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         ctrl_d1_ff <= mac_ctrl;
         ctrl_d2_ff <= ctrl_d1_ff;
         done_ff    <= done_in;
      end
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

>>> rtl/core/integer_matrix_multiply_core.sv
// Square integer matrix product, C = A x B, elements 16-bit signed, results wrapped to 32 bits.
// A load beat (operation 0) writes A and B at (row, col) and leaves busy low, so loads may
// follow every cycle while idle; a load outside the size in use is dropped. A read beat
// (operation 1) returns C(row, col) as one rsp_strobe beat. A read inside the size does one
// multiply-accumulate per cycle over one row of A and one column of B of the size in use
// (matrix_size capped at MAX_DIM), set by the single read port of each element store, each
// step passing through RAM read, multiply and accumulate, and then a result register. busy
// stays high from the cycle after the accept until the result beat. A read outside the size
// gives a zero result with rsp_out_of_range set in the cycle after the accept and keeps busy
// low. The receiver cannot stall: every rsp_strobe beat is valid for one cycle only. Write
// matrix_size only while idle. Reading an element never loaded gives an undefined value.
module integer_matrix_multiply_core #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic        [imm_pkg::IDX_W-1:0]  req_row,
   input  logic        [imm_pkg::IDX_W-1:0]  req_col,
   input  logic signed [imm_pkg::DATA_W-1:0] req_a_value,
   input  logic signed [imm_pkg::DATA_W-1:0] req_b_value,
   output logic                              rsp_strobe,
   output logic signed [imm_pkg::ACC_W-1:0]  rsp_product_value,
   output logic                              rsp_out_of_range,
   input  logic                              csr_write_enable,
   input  logic        [imm_pkg::SIZE_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

   logic [imm_pkg::SIZE_W-1:0]  csr_matrix_size_ff, csr_matrix_size_in;
   logic [imm_pkg::SIZE_W-1:0]  size_eff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [imm_pkg::ACC_W-1:0]   rsp_product_value_ff, rsp_product_value_in;
   logic                        rsp_out_of_range_ff, rsp_out_of_range_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr_a;
   logic [ADDR_W-1:0]           rd_addr_b;
   logic [imm_pkg::DATA_W-1:0]  a_data;
   logic [imm_pkg::DATA_W-1:0]  b_data;
   imm_pkg::mac_ctrl_type       mac_ctrl;
   logic                        oor_hit;
   logic                        mac_done;
   logic [imm_pkg::ACC_W-1:0]   mac_sum;

   always_comb begin
      csr_matrix_size_in = csr_write_enable ? csr_write_data : csr_matrix_size_ff;
      size_eff = (int'(csr_matrix_size_ff) > MAX_DIM) ? imm_pkg::SIZE_W'(MAX_DIM)
                                                       : csr_matrix_size_ff;
   end

   imm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .row       (req_row),
      .col       (req_col),
      .size_eff  (size_eff),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .mac_ctrl  (mac_ctrl),
      .oor_hit   (oor_hit)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_a_value),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_b_value),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   imm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctrl (mac_ctrl),
      .a_data   (a_data),
      .b_data   (b_data),
      .done     (mac_done),
      .sum      (mac_sum)
   );

   always_comb begin
      rsp_strobe_in        = mac_done || oor_hit;
      rsp_product_value_in = mac_done ? mac_sum : '0;
      rsp_out_of_range_in  = oor_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_matrix_size_ff <= imm_pkg::SIZE_W'(imm_pkg::SIZE_RESET);
         rsp_strobe_ff      <= 1'b0;
      end else begin
         csr_matrix_size_ff <= csr_matrix_size_in;
         rsp_strobe_ff      <= rsp_strobe_in;
      end
      rsp_product_value_ff <= rsp_product_value_in;
      rsp_out_of_range_ff  <= rsp_out_of_range_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_product_value = rsp_product_value_ff;
   assign rsp_out_of_range  = rsp_out_of_range_ff;

   `IMM_NEVER(a_no_beat_clash, clock, reset, mac_done && oor_hit, "result beats collide")
   `IMM_ASSERT(a_mac_while_busy, clock, reset, mac_ctrl.valid |-> busy, "MAC step while idle")
   `IMM_ASSERT(a_busy_on_read, clock, reset,
               $rose(busy) |-> ($past(start) && $past(req_operation)), "busy without read")
   `IMM_NEVER(a_write_while_busy, clock, reset, wr_en && busy, "store write during read")

endmodule
